// ===== rtl/hcn_pkg.sv =====
`default_nettype none
package hcn_pkg;

    // sizes
    localparam int MAX_COLUMNS = 1024;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int CNT_W       = COL_W + 1;
    localparam int HEIGHT_W    = 24;
    localparam int ROW_W       = 16;
    localparam int CFG_ADDR_W  = 5;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_GRID_COLUMNS  = 3'd0;
    localparam logic [2:0] REG_CELL_EAST     = 3'd1;
    localparam logic [2:0] REG_CELL_NORTH    = 3'd2;
    localparam logic [2:0] REG_EAST_START    = 3'd3;
    localparam logic [2:0] REG_NORTH_START   = 3'd4;
    localparam logic [2:0] REG_HEIGHT_CENTER = 3'd5;
    localparam logic [2:0] REG_VIEW_SCALE    = 3'd6;

    // clamp a position to +-2^32, enough to keep the saturated result
    function automatic logic signed [33:0] clamp_pos(input logic signed [63:0] v);
        logic signed [63:0] lim;
        lim = 64'sd1 <<< 32;
        if (v > lim) begin
            return 34'(lim);
        end else if (v < -lim) begin
            return 34'(-lim);
        end
        return 34'(v);
    endfunction

    // negate, round to nearest with ties up, then saturate to 16 bits
    function automatic logic [15:0] neg_round_sat(input logic signed [63:0] p,
                                                  input logic [4:0] sh);
        logic signed [63:0] t;
        t = (-p + (64'sd1 <<< (sh - 5'd1))) >>> sh;
        if (t > 64'sd32767) begin
            return 16'h7fff;
        end else if (t < -64'sd32768) begin
            return 16'h8000;
        end
        return t[15:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/hcn_ram.sv =====
`default_nettype none
module hcn_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/heightfield_cell_normals.sv =====
// heightfield cell normals: one vertex per closed 2x2 cell of a raster height stream
// steps from a cell-closing item to its result: 1 read, 9 multiply steps
// (8 products), normalize shifts, 4 square steps, 32 root steps, a 3 x 16 divider
// input is taken only in idle, so no new item is accepted until the previous one is through,
// and a result also waits while the previous result still sits in the output register
// reset: synchronous active-low aresetn clears counters, held samples and registers to
// their defaults; the line buffer is not cleared and no clearing pass runs
`default_nettype none
module heightfield_cell_normals
    import hcn_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [23:0]           s_tdata,   // height[23:0]
    input  wire logic                  s_tuser,   // frame_start
    // result items
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // pos_vertical[15:0], pos_east[31:16], pos_north[47:32],
    // normal_east[63:48], normal_north[79:64], normal_up[94:80], zero[95]
    output logic [95:0]                m_tdata,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_MUL, ST_NORM, ST_SQR, ST_ROOT, ST_DIV, ST_DONE
    } state_t;

    // configuration registers
    logic [10:0] grid_columns_reg;
    logic [23:0] cell_east_reg, cell_north_reg, view_scale_reg;
    logic signed [23:0] east_start_reg, north_start_reg, height_center_reg;

    logic cfg_wr;
    logic [2:0] cfg_idx;
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_columns_reg  <= 11'd2;
            cell_east_reg     <= 24'd256;
            cell_north_reg    <= 24'd256;
            east_start_reg    <= '0;
            north_start_reg   <= '0;
            height_center_reg <= '0;
            view_scale_reg    <= 24'd65536;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_GRID_COLUMNS:  grid_columns_reg  <= pwdata[10:0];
                REG_CELL_EAST:     cell_east_reg     <= pwdata[23:0];
                REG_CELL_NORTH:    cell_north_reg    <= pwdata[23:0];
                REG_EAST_START:    east_start_reg    <= pwdata[23:0];
                REG_NORTH_START:   north_start_reg   <= pwdata[23:0];
                REG_HEIGHT_CENTER: height_center_reg <= pwdata[23:0];
                REG_VIEW_SCALE:    view_scale_reg    <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (cfg_idx)
            REG_GRID_COLUMNS:  prdata = {21'd0, grid_columns_reg};
            REG_CELL_EAST:     prdata = {8'd0, cell_east_reg};
            REG_CELL_NORTH:    prdata = {8'd0, cell_north_reg};
            REG_EAST_START:    prdata = {8'd0, east_start_reg};
            REG_NORTH_START:   prdata = {8'd0, north_start_reg};
            REG_HEIGHT_CENTER: prdata = {8'd0, height_center_reg};
            REG_VIEW_SCALE:    prdata = {8'd0, view_scale_reg};
            default:           prdata = '0;
        endcase
    end

    // effective column count and pitches
    logic [CNT_W-1:0] cols;
    logic [23:0] de, dn;
    assign cols = (grid_columns_reg < 11'd2) ? CNT_W'(2) :
                  (grid_columns_reg > 11'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS) :
                  CNT_W'(grid_columns_reg);
    assign de = (cell_east_reg == '0) ? 24'd1 : cell_east_reg;
    assign dn = (cell_north_reg == '0) ? 24'd1 : cell_north_reg;

    state_t state_reg;
    logic [3:0] step_reg;

    // sample position counters
    logic [COL_W-1:0] column_count_reg;
    logic [ROW_W-1:0] row_count_reg;
    logic signed [23:0] prev_sample_reg, prev_above_reg, h_reg;
    logic [COL_W-1:0] cur_col_reg, e_reg;
    logic [ROW_W-1:0] n_reg;
    logic emit_reg;

    logic s_acc;
    logic [CNT_W-1:0] cc_full, nc_full;
    logic [ROW_W-1:0] rc, rc_next, row_count_next;
    logic [COL_W-1:0] column_count_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid & s_tready;

    // row and column of this item, then of the next
    always_comb begin
        cc_full = s_tuser ? '0 : CNT_W'(column_count_reg);
        rc      = s_tuser ? '0 : row_count_reg;
        if (cc_full >= cols) begin
            cc_full = '0;
            rc = (rc == '1) ? rc : rc + 1'b1;
        end
        nc_full = cc_full + 1'b1;
        rc_next = (rc == '1) ? rc : rc + 1'b1;
        if (nc_full >= cols) begin
            column_count_next = '0;
            row_count_next    = rc_next;
        end else begin
            column_count_next = nc_full[COL_W-1:0];
            row_count_next    = rc;
        end
    end

    // line buffer
    logic [23:0] above;
    hcn_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAX_COLUMNS)) u_line (
        .aclk    (aclk),
        .wr_en   (state_reg == ST_READ),
        .wr_addr (cur_col_reg),
        .wr_data (h_reg),
        .rd_en   (s_acc),
        .rd_addr (cc_full[COL_W-1:0]),
        .rd_data (above)
    );

    // cell terms
    logic signed [26:0] d_reg, nx_reg, ny_reg;
    logic signed [26:0] z0, z1, z2, z3;
    assign z0 = 27'(prev_above_reg);
    assign z1 = 27'($signed(above));
    assign z2 = 27'(prev_sample_reg);
    assign z3 = 27'(h_reg);

    // shared multiplier
    logic signed [34:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [66:0] mul_full;
    logic signed [63:0] prod_reg;
    logic signed [33:0] pos_e_reg, pos_n_reg;
    logic [51:0] a_mag_reg, b_mag_reg, c_mag_reg;
    logic a_neg_reg, b_neg_reg;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_MUL) begin
            case (step_reg)
                4'd0: begin mul_a = {25'd0, e_reg};  mul_b = {8'd0, de}; end
                4'd1: begin mul_a = {19'd0, n_reg};  mul_b = {8'd0, dn}; end
                4'd2: begin mul_a = 35'(d_reg);      mul_b = {8'd0, view_scale_reg}; end
                4'd3: begin mul_a = 35'(pos_e_reg);  mul_b = {8'd0, view_scale_reg}; end
                4'd4: begin mul_a = 35'(pos_n_reg);  mul_b = {8'd0, view_scale_reg}; end
                4'd5: begin mul_a = 35'(nx_reg);     mul_b = {7'd0, dn, 1'b0}; end
                4'd6: begin mul_a = 35'(ny_reg);     mul_b = {7'd0, de, 1'b0}; end
                4'd7: begin mul_a = {11'd0, de};     mul_b = {8'd0, dn}; end
                default: ;
            endcase
        end else if (state_reg == ST_SQR) begin
            case (step_reg)
                4'd0: begin mul_a = {5'd0, a_mag_reg[29:0]}; mul_b = {2'd0, a_mag_reg[29:0]}; end
                4'd1: begin mul_a = {5'd0, b_mag_reg[29:0]}; mul_b = {2'd0, b_mag_reg[29:0]}; end
                4'd2: begin mul_a = {5'd0, c_mag_reg[29:0]}; mul_b = {2'd0, c_mag_reg[29:0]}; end
                default: ;
            endcase
        end
    end
    assign mul_full = mul_a * mul_b;

    // root and divider state
    logic [63:0] acc_reg, x_reg, r_reg, bit_reg;
    logic [4:0] iter_reg;
    logic [30:0] len_reg;
    logic [45:0] rem_reg;
    logic [14:0] q_reg;
    logic [1:0] sel_reg;
    logic [63:0] root_t;
    logic [29:0] div_x;
    logic [45:0] div_d;
    logic [15:0] q_signed;
    assign root_t = r_reg + bit_reg;
    assign div_x  = (sel_reg == 2'd0) ? a_mag_reg[29:0] :
                    (sel_reg == 2'd1) ? b_mag_reg[29:0] : c_mag_reg[29:0];
    assign div_d  = 46'(len_reg) << step_reg;

    // results
    logic [15:0] pv_reg, pe_reg, pn_reg, ne_reg, nn_reg;
    logic [14:0] nu_reg;
    logic [15:0] o_pv_reg, o_pe_reg, o_pn_reg, o_ne_reg, o_nn_reg;
    logic [14:0] o_nu_reg;
    logic m_tvalid_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, o_nu_reg, o_nn_reg, o_ne_reg, o_pn_reg, o_pe_reg, o_pv_reg};

    // sequencer
    always_ff @(posedge aclk) begin
        prod_reg <= mul_full[63:0];
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            prev_sample_reg  <= '0;
            prev_above_reg   <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            // output register: load a finished vertex, or clear once taken
            if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        h_reg            <= s_tdata;
                        cur_col_reg      <= cc_full[COL_W-1:0];
                        emit_reg         <= (rc != '0) && (cc_full != '0);
                        e_reg            <= cc_full[COL_W-1:0] - 1'b1;
                        n_reg            <= rc - 1'b1;
                        column_count_reg <= column_count_next;
                        row_count_reg    <= row_count_next;
                        state_reg        <= ST_READ;
                    end
                end
                ST_READ: begin
                    prev_above_reg  <= above;
                    prev_sample_reg <= h_reg;
                    d_reg  <= z0 + z1 + z2 + z3 - (27'(height_center_reg) <<< 2);
                    nx_reg <= z0 - z1 + z2 - z3;
                    ny_reg <= z0 + z1 - z2 - z3;
                    step_reg  <= '0;
                    state_reg <= emit_reg ? ST_MUL : ST_IDLE;
                end
                ST_MUL: begin
                    step_reg <= step_reg + 1'b1;
                    // write back the product issued one step earlier
                    case (step_reg)
                        4'd1: pos_e_reg <= clamp_pos(64'(east_start_reg) + prod_reg);
                        4'd2: pos_n_reg <= clamp_pos(64'(north_start_reg) + prod_reg);
                        4'd3: pv_reg <= neg_round_sat(prod_reg, 5'd18);
                        4'd4: pe_reg <= neg_round_sat(prod_reg, 5'd16);
                        4'd5: pn_reg <= neg_round_sat(prod_reg, 5'd16);
                        4'd6: begin
                            a_neg_reg <= prod_reg[63];
                            a_mag_reg <= prod_reg[63] ? 52'(-prod_reg) : prod_reg[51:0];
                        end
                        4'd7: begin
                            b_neg_reg <= prod_reg[63];
                            b_mag_reg <= prod_reg[63] ? 52'(-prod_reg) : prod_reg[51:0];
                        end
                        4'd8: begin
                            c_mag_reg <= {prod_reg[49:0], 2'b00};
                            state_reg <= ST_NORM;
                        end
                        default: ;
                    endcase
                end
                ST_NORM: begin
                    // shift all three down until each fits in 30 bits
                    if ((a_mag_reg[51:30] | b_mag_reg[51:30] | c_mag_reg[51:30]) != '0) begin
                        a_mag_reg <= a_mag_reg >> 1;
                        b_mag_reg <= b_mag_reg >> 1;
                        c_mag_reg <= c_mag_reg >> 1;
                    end else begin
                        step_reg  <= '0;
                        acc_reg   <= '0;
                        state_reg <= ST_SQR;
                    end
                end
                ST_SQR: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 4'd3) begin
                        x_reg     <= acc_reg + prod_reg;
                        r_reg     <= '0;
                        bit_reg   <= 64'd1 << 62;
                        iter_reg  <= '0;
                        state_reg <= ST_ROOT;
                    end else if (step_reg != 4'd0) begin
                        acc_reg <= acc_reg + prod_reg;
                    end
                end
                ST_ROOT: begin
                    // one result bit per cycle
                    if (x_reg >= root_t) begin
                        x_reg <= x_reg - root_t;
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg  <= bit_reg >> 2;
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == 5'd31) begin
                        sel_reg   <= '0;
                        step_reg  <= 4'd15;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (step_reg == 4'd15) begin
                        if (iter_reg == 5'd0) begin
                            len_reg <= r_reg[30:0];
                        end
                        rem_reg  <= {2'b00, div_x, 14'd0} +
                                    46'((iter_reg == 5'd0 ? r_reg[30:0] : len_reg) >> 1);
                        q_reg    <= '0;
                        iter_reg <= 5'd1;
                        step_reg <= 4'd14;
                    end else begin
                        if (rem_reg >= div_d) begin
                            rem_reg <= rem_reg - div_d;
                            q_reg[step_reg] <= 1'b1;
                        end
                        if (step_reg == 4'd0) begin
                            step_reg <= 4'd15;
                            sel_reg  <= sel_reg + 1'b1;
                            case (sel_reg)
                                2'd0: ne_reg <= a_neg_reg ? -q_signed : q_signed;
                                2'd1: nn_reg <= b_neg_reg ? -q_signed : q_signed;
                                default: begin
                                    nu_reg    <= q_signed[14:0];
                                    state_reg <= ST_DONE;
                                end
                            endcase
                        end else begin
                            step_reg <= step_reg - 1'b1;
                        end
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        o_pv_reg     <= pv_reg;
                        o_pe_reg     <= pe_reg;
                        o_pn_reg     <= pn_reg;
                        o_ne_reg     <= ne_reg;
                        o_nn_reg     <= nn_reg;
                        o_nu_reg     <= nu_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // final quotient including the bit decided this cycle
    assign q_signed = {1'b0, q_reg | ((rem_reg >= div_d) ? 15'(15'd1 << step_reg) : 15'd0)};

endmodule
`default_nettype wire
